[rtl/erm_pkg.sv]
// shared types, constants and digit helpers for the echo range and speed meter
package erm_pkg;

   // event codes on the request word
   localparam logic [1:0] FUNC_RISE = 2'd0;
   localparam logic [1:0] FUNC_FALL = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // divide by 116 as a multiply by a rounded-up reciprocal and a shift, exact for 16 bits
   localparam logic [16:0] DIV116_MULT  = 17'd72316;
   localparam int          DIV116_SHIFT = 23;

   localparam logic [9:0] DIST_LIMIT  = 10'd431;
   localparam logic [11:0] SPEED_LIMIT = 12'd862;
   localparam logic [5:0] ASCII_ZERO  = 6'd48;
   localparam logic [5:0] ASCII_NINE  = 6'd57;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] capture_count;
   } req_word_type;

   typedef struct packed {
      logic       distance_valid;
      logic [5:0] distance_hundreds;
      logic [5:0] distance_tens;
      logic [5:0] distance_ones;
      logic       speed_valid;
      logic       speed_negative;
      logic [5:0] speed_hundreds;
      logic [5:0] speed_tens;
      logic [5:0] speed_ones;
   } rsp_word_type;

   // one classified event waiting between front and back
   typedef struct packed {
      logic       is_tick;
      logic [9:0] distance;
   } q_entry_type;

   // hundreds digit of a value below 1000: v * 41 / 4096
   function automatic logic [3:0] hundreds_of(input logic [9:0] v);
      logic [15:0] prod;
      prod = 16'(v) * 16'd41;
      return prod[15:12];
   endfunction

   // tens digit of a value below 100: r * 205 / 2048
   function automatic logic [3:0] tens_of(input logic [6:0] r);
      logic [14:0] prod;
      prod = 15'(r) * 15'd205;
      return prod[14:11];
   endfunction

endpackage

[rtl/erm_front.sv]
// front end: takes event words, tracks the rise count and turns falls into distances
module erm_front import erm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   input  logic         q_full,
   output logic         q_push,
   output q_entry_type  q_entry
);

   logic [15:0] rise_ff, rise_in;
   logic [15:0] width;
   logic [32:0] product;
   logic        accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // wrapped pulse width and centimetres
   assign width   = req_word.capture_count - rise_ff;
   assign product = 33'(width) * 33'(DIV116_MULT);

   // classify the word
   always_comb begin
      rise_in          = rise_ff;
      q_push           = 1'b0;
      q_entry.is_tick  = 1'b0;
      q_entry.distance = product[DIV116_SHIFT +: 10];
      unique case (req_word.func)
         FUNC_RISE: begin
            if (accept) begin
               rise_in = req_word.capture_count;
            end
         end
         FUNC_FALL: begin
            q_push = accept;
         end
         FUNC_TICK: begin
            q_push          = accept;
            q_entry.is_tick = 1'b1;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= '0;
      end else begin
         rise_ff <= rise_in;
      end
   end

endmodule

[rtl/erm_queue.sv]
// small first-in first-out queue between front and back
module erm_queue import erm_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output q_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   q_entry_type      mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/erm_back.sv]
// back end: distance state, speed, digit split and the result register
module erm_back import erm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  q_entry_type  q_entry,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   typedef struct packed {
      logic       dist_valid;
      logic [9:0] dist_value;
      logic       speed_valid;
      logic       speed_negative;
      logic [9:0] speed_value;
   } stage1_type;

   typedef struct packed {
      logic       dist_valid;
      logic [3:0] dist_h;
      logic [6:0] dist_rem;
      logic       speed_valid;
      logic       speed_negative;
      logic [3:0] speed_h;
      logic [6:0] speed_rem;
   } stage2_type;

   logic [9:0]   cur_dist_ff, cur_dist_in;
   logic [9:0]   prev_dist_ff, prev_dist_in;
   logic         primed_ff, primed_in;
   logic         s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   stage1_type   s1_ff, s1_in;
   stage2_type   s2_ff, s2_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         adv;
   logic         tick_pop;
   logic [10:0]  diff;
   logic [10:0]  diff_mag;
   logic [11:0]  speed_mag;
   logic         speed_ok;
   logic [3:0]  dist_t, speed_t;
   logic [6:0]  dist_o7, speed_o7;

   // whole pipe moves when the result register is free or drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign q_pop     = adv && q_valid;
   assign tick_pop  = q_pop && q_entry.is_tick;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // signed change since the last tick, doubled
   assign diff      = {1'b0, cur_dist_ff} - {1'b0, prev_dist_ff};
   assign diff_mag  = diff[10] ? (11'd0 - diff) : diff;
   assign speed_mag = {diff_mag, 1'b0};
   assign speed_ok  = primed_ff && (speed_mag <= SPEED_LIMIT);

   // distance state and first stage
   always_comb begin
      cur_dist_in  = cur_dist_ff;
      prev_dist_in = prev_dist_ff;
      primed_in    = primed_ff;
      if (q_pop && !q_entry.is_tick) begin
         cur_dist_in = q_entry.distance;
      end
      if (tick_pop) begin
         prev_dist_in = cur_dist_ff;
         primed_in    = 1'b1;
      end
      s1_in.dist_valid     = (cur_dist_ff < DIST_LIMIT);
      s1_in.dist_value     = s1_in.dist_valid ? cur_dist_ff : '0;
      s1_in.speed_valid    = speed_ok;
      s1_in.speed_negative = speed_ok && diff[10];
      s1_in.speed_value    = speed_ok ? speed_mag[9:0] : '0;
   end

   // hundreds digit and remainder
   always_comb begin
      logic [9:0] d_r;
      logic [9:0] s_r;
      s2_in.dist_valid     = s1_ff.dist_valid;
      s2_in.speed_valid    = s1_ff.speed_valid;
      s2_in.speed_negative = s1_ff.speed_negative;
      s2_in.dist_h         = hundreds_of(s1_ff.dist_value);
      s2_in.speed_h        = hundreds_of(s1_ff.speed_value);
      d_r = s1_ff.dist_value - 10'(s2_in.dist_h) * 10'd100;
      s_r = s1_ff.speed_value - 10'(s2_in.speed_h) * 10'd100;
      s2_in.dist_rem  = d_r[6:0];
      s2_in.speed_rem = s_r[6:0];
   end

   // tens and ones, then ascii
   always_comb begin
      dist_t   = tens_of(s2_ff.dist_rem);
      speed_t  = tens_of(s2_ff.speed_rem);
      dist_o7  = s2_ff.dist_rem - 7'(dist_t) * 7'd10;
      speed_o7 = s2_ff.speed_rem - 7'(speed_t) * 7'd10;
      rsp_word_in.distance_valid    = s2_ff.dist_valid;
      rsp_word_in.distance_hundreds = ASCII_ZERO + 6'(s2_ff.dist_h);
      rsp_word_in.distance_tens     = ASCII_ZERO + 6'(dist_t);
      rsp_word_in.distance_ones     = ASCII_ZERO + 6'(dist_o7[3:0]);
      rsp_word_in.speed_valid       = s2_ff.speed_valid;
      rsp_word_in.speed_negative    = s2_ff.speed_negative;
      rsp_word_in.speed_hundreds    = ASCII_ZERO + 6'(s2_ff.speed_h);
      rsp_word_in.speed_tens        = ASCII_ZERO + 6'(speed_t);
      rsp_word_in.speed_ones        = ASCII_ZERO + 6'(speed_o7[3:0]);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_dist_ff  <= '0;
         prev_dist_ff <= '0;
         primed_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_dist_ff  <= cur_dist_in;
         prev_dist_ff <= prev_dist_in;
         primed_ff    <= primed_in;
         if (adv) begin
            s1_valid_ff  <= tick_pop;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         rsp_word_ff <= rsp_word_in;
      end
   end

`ifndef SYNTHESIS
   a_neg_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.speed_negative |-> rsp_word_ff.speed_valid)
      else $error("negative speed flagged on an invalid speed");

   a_primed_sticks: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("primed flag dropped");

   a_range_zeroed: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_ff.dist_valid |-> s1_ff.dist_value == 10'd0)
      else $error("out of range distance not zeroed");

   a_digit_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.distance_ones >= ASCII_ZERO
                       && rsp_word_ff.distance_ones <= ASCII_NINE
                       && rsp_word_ff.speed_ones >= ASCII_ZERO
                       && rsp_word_ff.speed_ones <= ASCII_NINE)
      else $error("ones digit outside ascii range");
`endif

endmodule

[rtl/echo_range_and_speed_meter_core.sv]
// top level of the echo range and speed meter
// one word accepted per cycle while the queue has room; rise and unused words give no result
// a tick word's result, when the result side is ready, passes through
// the queue write, the distance/speed stage, the digit stage and the result register
// falls and ticks travel through a QUEUE_DEPTH word queue, so each side may stall alone
// synchronous active-high reset clears rise count, distances, primed flag and all valids
module echo_range_and_speed_meter_core import erm_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_valid;
   q_entry_type q_in;
   q_entry_type q_head;

   erm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in)
   );

   erm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   erm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

[tb/tb_echo_range_and_speed_meter_core.sv]
// testbench for the echo range and speed meter core: directed and random words, scoreboard check
`timescale 1ns / 100ps

module tb_echo_range_and_speed_meter_core;
   import erm_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int COUNTS_PER_CM = 116;
   localparam int MAX_CM        = 564;   // widest 16-bit pulse over 116
   localparam int WORD_TARGET   = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int REPORT_MAX    = 10;

   // predicted meter state and expected result words
   class meter_scoreboard;
      logic [15:0]  rise_count;
      logic [9:0]   cur_cm;
      logic [9:0]   prev_cm;
      bit           primed;
      rsp_word_type expected_q[$];
      int           mismatches;

      function new();
         rise_count = '0;
         cur_cm     = '0;
         prev_cm    = '0;
         primed     = 1'b0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // update state for one accepted request word, queue a result on a tick
      function void note_word(req_word_type w);
         logic [15:0]  width;
         rsp_word_type want;
         int           speed;
         int           mag;
         case (w.func)
            FUNC_RISE: begin
               rise_count = w.capture_count;
            end
            FUNC_FALL: begin
               width  = w.capture_count - rise_count;
               cur_cm = 10'(int'(width) / COUNTS_PER_CM);
            end
            FUNC_TICK: begin
               want = '0;
               want.distance_hundreds = ASCII_ZERO;
               want.distance_tens     = ASCII_ZERO;
               want.distance_ones     = ASCII_ZERO;
               want.speed_hundreds    = ASCII_ZERO;
               want.speed_tens        = ASCII_ZERO;
               want.speed_ones        = ASCII_ZERO;
               // distance digits, shown only below the range limit
               if (cur_cm < DIST_LIMIT) begin
                  want.distance_valid    = 1'b1;
                  want.distance_hundreds = ASCII_ZERO + 6'((int'(cur_cm) / 100) % 10);
                  want.distance_tens     = ASCII_ZERO + 6'((int'(cur_cm) / 10) % 10);
                  want.distance_ones     = ASCII_ZERO + 6'(int'(cur_cm) % 10);
               end
               // signed speed over the half-second tick, after the first tick only
               speed = (int'(cur_cm) - int'(prev_cm)) * 2;
               mag   = (speed < 0) ? -speed : speed;
               if (primed && mag <= int'(SPEED_LIMIT)) begin
                  want.speed_valid    = 1'b1;
                  want.speed_negative = (speed < 0);
                  want.speed_hundreds = ASCII_ZERO + 6'((mag / 100) % 10);
                  want.speed_tens     = ASCII_ZERO + 6'((mag / 10) % 10);
                  want.speed_ones     = ASCII_ZERO + 6'(mag % 10);
               end
               prev_cm = cur_cm;
               primed  = 1'b1;
               expected_q.push_back(want);
            end
            default: ;   // unused selector leaves the state alone
         endcase
      endfunction

      // compare one accepted result word against the oldest expectation
      function void check_word(rsp_word_type got);
         rsp_word_type want;
         bit           bad;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result word %h", got);
            return;
         end
         want = expected_q.pop_front();
         bad = (got.distance_valid    !== want.distance_valid)
            || (got.distance_hundreds !== want.distance_hundreds)
            || (got.distance_tens     !== want.distance_tens)
            || (got.distance_ones     !== want.distance_ones)
            || (got.speed_valid       !== want.speed_valid)
            || (got.speed_negative    !== want.speed_negative)
            || (got.speed_hundreds    !== want.speed_hundreds)
            || (got.speed_tens        !== want.speed_tens)
            || (got.speed_ones        !== want.speed_ones);
         if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("result mismatch: expected dist %b %0d %0d %0d speed %b %b %0d %0d %0d",
                        want.distance_valid, want.distance_hundreds, want.distance_tens,
                        want.distance_ones, want.speed_valid, want.speed_negative,
                        want.speed_hundreds, want.speed_tens, want.speed_ones);
               $display("                 actual   dist %b %0d %0d %0d speed %b %b %0d %0d %0d",
                        got.distance_valid, got.distance_hundreds, got.distance_tens,
                        got.distance_ones, got.speed_valid, got.speed_negative,
                        got.speed_hundreds, got.speed_tens, got.speed_ones);
            end
         end
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   meter_scoreboard meter;
   bit              tx_calm = 1'b0;
   bit              rx_calm = 1'b0;
   bit              hold_now = 1'b0;
   int              sent_words = 0;
   int unsigned     cycle_count = 0;

   echo_range_and_speed_meter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL echo_range_and_speed_meter_core");
         $finish;
      end
   end

   // offer one request word after a random gap, wait for acceptance
   task automatic offer(input logic [1:0] f, input logic [15:0] c);
      req_word_type w;
      int           gap;
      w.func          = f;
      w.capture_count = c;
      gap = tx_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      meter.note_word(w);
      if (f != FUNC_UNUSED)
         sent_words++;
   endtask

   // rise and fall pair that lands on the given distance in cm
   task automatic measure(input int cm);
      logic [15:0] base;
      int          width;
      base  = 16'($urandom);
      width = cm * COUNTS_PER_CM + $urandom_range(0, COUNTS_PER_CM - 1);
      if (width > 65535)
         width = 65535;
      offer(FUNC_RISE, base);
      offer(FUNC_FALL, base + 16'(width));
   endtask

   // hold the line quiet until every expected result is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (meter.pending() != 0);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      int taken;
      taken = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_now) begin
            hold_now = 1'b0;
            stall    = HOLD_CYCLES;
         end else begin
            stall = rx_calm ? 0 : $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         meter.check_word(rsp_word);
         taken++;
         if (taken % 64 == 0)
            rx_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // request side: reset, directed words, random sequences, end of run
   initial begin
      int  kind;
      int  cm;
      int  last_cm;
      bit  held;
      bit  paused;
      meter   = new();
      last_cm = 0;
      held    = 1'b0;
      paused  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fall with no rise since reset, then the priming tick
      offer(FUNC_FALL, 16'd1160);
      offer(FUNC_TICK, 16'h0000);
      offer(FUNC_UNUSED, 16'hFFFF);
      // largest valid distance, then first out-of-range distance
      offer(FUNC_RISE, 16'h0000);
      offer(FUNC_FALL, 16'd49880);
      offer(FUNC_TICK, 16'hFFFF);
      offer(FUNC_FALL, 16'd49996);
      offer(FUNC_TICK, 16'h5555);
      // one-count pulse across the wrap: fastest valid approach
      offer(FUNC_RISE, 16'hFFFF);
      offer(FUNC_FALL, 16'h0000);
      offer(FUNC_TICK, 16'hAAAA);
      // speed just past the limit going away
      offer(FUNC_RISE, 16'h0000);
      offer(FUNC_FALL, 16'd50112);
      offer(FUNC_TICK, 16'h0000);
      // wrapped pulse width
      offer(FUNC_RISE, 16'd65500);
      offer(FUNC_FALL, 16'd1000);
      offer(FUNC_TICK, 16'h0000);
      // widest pulse, then a still object
      offer(FUNC_RISE, 16'h0000);
      offer(FUNC_FALL, 16'hFFFF);
      offer(FUNC_TICK, 16'h0000);
      offer(FUNC_TICK, 16'h0000);
      offer(FUNC_UNUSED, 16'hAAAA);
      offer(FUNC_TICK, 16'h5555);
      drain();

      // random sequences, mostly well formed
      while (sent_words < WORD_TARGET) begin
         tx_calm = ((sent_words / 150) % 4 == 3);
         // long receiver hold-off while ticks keep coming
         if (!held && sent_words >= 600) begin
            held     = 1'b1;
            hold_now = 1'b1;
            repeat (12) offer(FUNC_TICK, 16'($urandom));
         end
         if (!paused && sent_words >= 1200) begin
            paused = 1'b1;
            drain();
         end
         // next distance: near the last one, near the range limit, or anywhere
         case ($urandom_range(0, 5))
            0:       cm = $urandom_range(0, MAX_CM);
            1:       cm = $urandom_range(428, 434);
            default: cm = last_cm + $urandom_range(0, 862) - 431;
         endcase
         if (cm < 0)
            cm = 0;
         if (cm > MAX_CM)
            cm = MAX_CM;
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            measure(cm);
            offer(FUNC_TICK, 16'($urandom));
            if ($urandom_range(0, 7) == 0)
               offer(FUNC_TICK, 16'($urandom));
            last_cm = cm;
         end else if (kind == 6) begin
            measure(cm);
         end else if (kind <= 8) begin
            offer(2'($urandom_range(0, 3)), 16'($urandom));
         end else if ($urandom_range(0, 1) == 0) begin
            // fall against a stale rise
            offer(FUNC_FALL, 16'($urandom));
            offer(FUNC_TICK, 16'($urandom));
         end else begin
            // doubled rise, only the second counts
            offer(FUNC_RISE, 16'($urandom));
            measure(cm);
            offer(FUNC_TICK, 16'($urandom));
            last_cm = cm;
         end
      end

      // end of run
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (meter.mismatches == 0 && meter.pending() == 0)
         $display("PASS echo_range_and_speed_meter_core");
      else
         $display("FAIL echo_range_and_speed_meter_core");
      $finish;
   end

endmodule
